// File: rtl/core/text_console_writer_assert.svh
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int LIN_W  = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ACT_W  = 2;
    localparam int LINF_W = ROW_W + COL_W;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SET   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [ATTR_W-1:0] ERASE_ATTR = 8'h0F;

    localparam int TAB_STEP    = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_BACKSPACE,
        OP_READ,
        OP_CLEAR,
        OP_SET_CURSOR
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_COPY,
        S_BLANK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              in_range;
    } t_cmd;

    typedef struct packed {
        logic              scroll;
        logic [CELL_W-1:0] cell_data;
        logic [LIN_W-1:0]  lin;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_front.sv
// Front end: accept input words and classify them into commands.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic [ROW_W-1:0]  i_target_row,
    input  wire logic [COL_W-1:0]  i_target_col,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output t_cmd                   o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd          = '0;
        n_cmd.ch       = i_char_code;
        n_cmd.row      = i_target_row;
        n_cmd.col      = i_target_col;
        n_cmd.in_range = (32'(i_target_row) < ROWS) && (32'(i_target_col) < COLUMNS);
        unique case (i_action)
            ACT_PUT: begin
                unique case (i_char_code)
                    CH_NEWLINE:   n_cmd.op = OP_NEWLINE;
                    CH_TAB:       n_cmd.op = OP_TAB;
                    CH_BACKSPACE: n_cmd.op = OP_BACKSPACE;
                    default:      n_cmd.op = OP_PUT_CHAR;
                endcase
            end
            ACT_READ:  n_cmd.op = OP_READ;
            ACT_CLEAR: n_cmd.op = OP_CLEAR;
            ACT_SET:   n_cmd.op = OP_SET_CURSOR;
            default:   n_cmd.op = OP_SET_CURSOR;
        endcase
    end

    // Hold the classified word until the queue takes it.
    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_fifo.sv
// Short command queue between the front and back ends.
`default_nettype none

module tcw_fifo import tcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcw_back.sv
// Back end: cursor, screen store and the fill, scroll and access sequencer.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ATTR_W-1:0] i_attr,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd              i_cmd,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);

    t_state r_state;
    t_state n_state;

    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_pend;
    logic              n_pend;
    logic [AW-1:0]     r_wr_addr;
    logic [AW-1:0]     n_wr_addr;
    logic [CELL_W-1:0] r_fill;
    logic [CELL_W-1:0] n_fill;
    logic              r_scroll;
    logic              n_scroll;
    logic              r_rd_ok;
    logic              n_rd_ok;
    logic              r_bs;
    logic              n_bs;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              out_free;
    logic              take;
    logic              is_put;
    logic              need_scroll;
    logic [COL_W:0]    col_p1;
    logic [COL_W:0]    tab_col;
    logic [ROW_W:0]    row_p1;
    logic [ROW_W:0]    put_row;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  mul_row;
    logic [COL_W-1:0]  mul_col;
    logic [LINF_W-1:0] lin;
    logic [AW-1:0]     addr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign out_free    = !r_out_valid || i_res_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign take        = o_cmd_ready && i_cmd_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // One address multiplier: the target cell for a read, the cursor otherwise.
    assign mul_row = ((r_state == S_IDLE) && (i_cmd.op == OP_READ)) ? i_cmd.row : r_row;
    assign mul_col = ((r_state == S_IDLE) && (i_cmd.op == OP_READ)) ? i_cmd.col : r_col;
    assign lin     = LINF_W'(mul_row) * LINF_W'(COLUMNS) + LINF_W'(mul_col);
    assign addr    = lin[AW-1:0];

    assign col_p1  = {1'b0, r_col} + (COL_W+1)'(1);
    assign tab_col = ({1'b0, r_col} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
    assign row_p1  = {1'b0, r_row} + (ROW_W+1)'(1);

    // Cursor movement of the put commands, before any scroll.
    always_comb begin
        put_row = {1'b0, r_row};
        put_col = r_col;
        is_put  = 1'b0;
        unique case (i_cmd.op)
            OP_NEWLINE: begin
                is_put  = 1'b1;
                put_row = row_p1;
                put_col = '0;
            end
            OP_TAB: begin
                is_put = 1'b1;
                if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                    put_row = row_p1;
                    put_col = '0;
                end else begin
                    put_col = tab_col[COL_W-1:0];
                end
            end
            OP_BACKSPACE: begin
                is_put = 1'b1;
                if (r_col != '0) begin
                    put_col = r_col - COL_W'(1);
                end else if (r_row != '0) begin
                    put_row = {1'b0, r_row} - (ROW_W+1)'(1);
                    put_col = COL_W'(COLUMNS - 1);
                end
            end
            OP_PUT_CHAR: begin
                is_put = 1'b1;
                if (col_p1 >= (COL_W+1)'(COLUMNS)) begin
                    put_row = row_p1;
                    put_col = '0;
                end else begin
                    put_col = col_p1[COL_W-1:0];
                end
            end
            default: begin
                is_put = 1'b0;
            end
        endcase
    end

    assign need_scroll = is_put && (put_row >= (ROW_W+1)'(ROWS));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_idx == CNT_W'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    if (i_cmd.op == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (need_scroll) begin
                        n_state = S_COPY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                if (r_idx == CNT_W'(CELLS - 1)) n_state = S_DONE;
            end
            S_COPY: begin
                if (r_idx == CNT_W'(CELLS)) n_state = S_BLANK;
            end
            S_BLANK: begin
                if (r_idx == CNT_W'(CELLS - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and store controls per state.
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_wr_addr   = r_wr_addr;
        n_fill      = r_fill;
        n_scroll    = r_scroll;
        n_rd_ok     = r_rd_ok;
        n_bs        = r_bs;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        ram_we      = 1'b0;
        ram_waddr   = addr;
        ram_wdata   = r_fill;
        ram_re      = 1'b0;
        ram_raddr   = addr;
        unique case (r_state) inside
            S_INIT, S_CLEAR, S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                n_idx     = r_idx + CNT_W'(1);
            end
            S_IDLE: begin
                if (take) begin
                    n_scroll = 1'b0;
                    n_rd_ok  = 1'b0;
                    n_bs     = 1'b0;
                    unique case (i_cmd.op)
                        OP_PUT_CHAR: begin
                            ram_we    = 1'b1;
                            ram_wdata = {i_attr, i_cmd.ch};
                        end
                        OP_BACKSPACE: begin
                            n_bs = 1'b1;
                        end
                        OP_READ: begin
                            ram_re  = 1'b1;
                            n_rd_ok = i_cmd.in_range;
                        end
                        OP_CLEAR: begin
                            n_idx  = '0;
                            n_fill = {i_attr, BLANK_CHAR};
                        end
                        OP_SET_CURSOR: begin
                            if (i_cmd.in_range) begin
                                n_row = i_cmd.row;
                                n_col = i_cmd.col;
                            end
                        end
                        default: begin
                            n_bs = 1'b0;
                        end
                    endcase
                    if (is_put) begin
                        n_row = put_row[ROW_W-1:0];
                        n_col = put_col;
                    end
                    if (i_cmd.op == OP_CLEAR) begin
                        n_row = '0;
                        n_col = '0;
                    end
                    if (need_scroll) begin
                        n_row    = ROW_W'(ROWS - 1);
                        n_scroll = 1'b1;
                        n_idx    = CNT_W'(COLUMNS);
                        n_pend   = 1'b0;
                    end
                end
            end
            S_COPY: begin
                // Read one row ahead, write the word read last cycle.
                ram_we    = r_pend;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
                if (r_idx == CNT_W'(CELLS)) begin
                    n_pend = 1'b0;
                    n_idx  = CNT_W'((ROWS - 1) * COLUMNS);
                    n_fill = {i_attr, BLANK_CHAR};
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_addr = AW'(r_idx - CNT_W'(COLUMNS));
                    n_idx     = r_idx + CNT_W'(1);
                end
            end
            S_DONE: begin
                ram_we      = r_bs;
                ram_wdata   = {ERASE_ATTR, BLANK_CHAR};
                n_out_valid = 1'b1;
                n_out.row   = r_row;
                n_out.col   = r_col;
                n_out.lin   = lin[LIN_W-1:0];
                n_out.cell_data = r_rd_ok ? ram_rdata : '0;
                n_out.scroll = r_scroll;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_fill      <= {RESET_ATTR, BLANK_CHAR};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_scroll  <= n_scroll;
        r_rd_ok   <= n_rd_ok;
        r_bs      <= n_bs;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// Text console writer: top level with configuration register and stream ports.
//
// Usage. Command words enter on the slave stream: tuser carries the action
// (put character, read cell, clear screen, set cursor) and tdata the
// character and the target cell. Every command returns exactly one word on
// the master stream with the cursor after the command, its linear position,
// the cell read (zero unless a read hits the screen) and a scroll flag.
// The attribute byte for written characters and for the blanks of a clear or a scroll is set through the
// cfg channel, which is always ready; write it only while the console is idle.
//
// Flow. A command passes a classifying register and a two-word queue, then the
// sequencer, which takes it in S_IDLE and registers its result word in S_DONE;
// it takes no new command until it is back in S_IDLE. A clear sweeps the store
// at one cell a cycle; a scroll copies each cell below the top row up one row and
// blanks the bottom row, limited by the single write port of the screen store.
// Reset. The cursor goes to the home position and the attribute to 0x07; the
// store is then filled with blanks in S_INIT, during which the sequencer takes
// no command and at most three wait in the register and queue.
// A stalled master side holds its word; the queue keeps taking commands until
// it and the classifying register are full, then tready drops.
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Command stream.
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [23:0]       i_s_axis_tdata,  // char_code, target_row, target_col, zero pad
    input  wire logic [ACT_W-1:0]  i_s_axis_tuser,  // action
    // Result stream.
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [39:0]            o_m_axis_tdata,  // cursor_row, cursor_col, cursor_linear,
                                                    // cell_data, did_scroll
    // Attribute register write.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [ATTR_W-1:0] i_cfg_data
);

    logic [ATTR_W-1:0] r_attr;

    logic    front_valid;
    logic    front_ready;
    t_cmd    front_cmd;
    logic    queue_valid;
    logic    queue_ready;
    t_cmd    queue_cmd;
    logic    res_valid;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr <= i_cfg_data;
        end
    end

    // Decode and register the incoming word.
    tcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_char_code (i_s_axis_tdata[7:0]),
        .i_target_row(i_s_axis_tdata[12:8]),
        .i_target_col(i_s_axis_tdata[19:13]),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // Decouple the front from long clears and scrolls.
    tcw_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(front_valid),
        .o_ready(front_ready),
        .i_cmd  (front_cmd),
        .o_valid(queue_valid),
        .i_ready(queue_ready),
        .o_cmd  (queue_cmd)
    );

    // Carry out commands against the cursor and the screen store.
    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     (r_attr),
        .i_cmd_valid(queue_valid),
        .o_cmd_ready(queue_ready),
        .i_cmd      (queue_cmd),
        .o_res_valid(res_valid),
        .i_res_ready(i_m_axis_tready),
        .o_res      (res)
    );

    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tdata  = {res.scroll, res.cell_data, res.lin, res.col, res.row};

    // Reported cursor always lies on the screen.
    `TCW_ASSERT_IMPL(a_cursor_on_screen, i_clk, i_rst_n, o_m_axis_tvalid,
        (32'(o_m_axis_tdata[4:0]) < ROWS) && (32'(o_m_axis_tdata[11:5]) < COLUMNS),
        "cursor off screen")

    // A scroll always leaves the cursor on the bottom row.
    `TCW_ASSERT_IMPL(a_scroll_bottom_row, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[39],
        32'(o_m_axis_tdata[4:0]) == (ROWS - 1),
        "scroll without cursor on bottom row")

    // Linear position agrees with row and column.
    `TCW_ASSERT_IMPL(a_linear_match, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[22:12] ==
            LIN_W'(32'(o_m_axis_tdata[4:0]) * COLUMNS + 32'(o_m_axis_tdata[11:5])),
        "linear cursor mismatch")

    // The sequencer never takes a command while a result is stuck.
    `TCW_ASSERT_IMPL(a_no_take_when_blocked, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, !queue_ready,
        "command taken while result stalled")

endmodule

`default_nettype wire
